// ===== hdl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, constants and helpers of the binary heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int CAPACITY    = 64;
    localparam int KEY_W       = 32;
    localparam int HANDLE_W    = 6;
    localparam int NUM_HANDLES = 64;
    localparam int POS_W       = 7;   // holds 0..CAPACITY
    localparam int IDX_W       = 6;   // memory index, position minus one
    localparam int PADDR_W     = 2;

    localparam logic [PADDR_W-1:0] ADDR_MIN_FIRST = 2'd0;

    localparam logic [2:0] REQ_INSERT  = 3'd0;
    localparam logic [2:0] REQ_DEQUEUE = 3'd1;
    localparam logic [2:0] REQ_PEEK    = 3'd2;
    localparam logic [2:0] REQ_REMOVE  = 3'd3;
    localparam logic [2:0] REQ_LOCATE  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
        logic [POS_W-1:0]    position;
    } hpq_req_t;

    typedef struct packed {
        status_t             status;
        logic [KEY_W-1:0]    out_key;
        logic [HANDLE_W-1:0] out_handle;
        logic [POS_W-1:0]    out_position;
        logic [POS_W-1:0]    entry_count;
    } hpq_rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_FLAG,
        OP_INS_WR,
        OP_RD_PARENT,
        OP_UP_W1,
        OP_UP_W2,
        OP_RD_ROOT,
        OP_DQ_W,
        OP_PEEK,
        OP_RD_REM,
        OP_RM_W1,
        OP_RM_W2,
        OP_RM_LAST,
        OP_RD_KIDS,
        OP_DN_W1,
        OP_DN_W2,
        OP_RD_SLOT,
        OP_LOC_OUT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t flag;
    } hpq_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       full;
        logic       empty;
        logic       bad_pos;
        logic       pos_last;
        logic       up_go;
        logic       dn_go;
    } hpq_stat_t;

    function automatic logic beats(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                   input logic min_first);
        beats = min_first ? (a < b) : (a > b);
    endfunction

    function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W:0] p);
        logic [POS_W:0] d;
        d = p - 1'b1;
        pos_to_idx = d[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/hpq_datapath.sv =====
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap and handle-slot memories, working entry and result registers.
// ----------------------------------------------------------------------------
module hpq_datapath import hpq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      min_first,
    input  hpq_req_t  s_data,
    input  hpq_cmd_t  cmd,
    output hpq_stat_t stat,
    output hpq_rsp_t  rsp
);

    entry_t            heap_mem [CAPACITY];
    logic [POS_W-1:0]  slot_mem [NUM_HANDLES];

    hpq_req_t          req_reg;
    logic [POS_W-1:0]  count_reg;
    entry_t            cur_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pick_reg;
    entry_t            child_reg;
    entry_t            rd_a_reg;
    entry_t            rd_b_reg;
    logic [POS_W-1:0]  slot_rd_reg;
    status_t           status_reg;
    logic [KEY_W-1:0]  okey_reg;
    logic [HANDLE_W-1:0] ohdl_reg;
    logic [POS_W-1:0]  opos_reg;

    logic [POS_W:0]    parent_pos, left_pos, right_pos, count_ext, cnt_inc, pick_pos;
    logic              left_ok, right_wins, pick_any;
    entry_t            pick_ent;

    logic              rd_en, wr_en, sw_en;
    logic [IDX_W-1:0]  rd_a_idx, rd_b_idx, wr_idx;
    entry_t            wr_data;
    logic [HANDLE_W-1:0] sw_hdl;
    logic [POS_W-1:0]  sw_pos;

    assign parent_pos = {1'b0, pos_reg} >> 1;
    assign left_pos   = {pos_reg, 1'b0};
    assign right_pos  = left_pos + 1'b1;
    assign count_ext  = {1'b0, count_reg};
    assign cnt_inc    = count_ext + 1'b1;
    assign left_ok    = left_pos <= count_ext;
    // right child only wins on strictly higher priority; ties go left
    assign right_wins = (right_pos <= count_ext) && beats(rd_b_reg.key, rd_a_reg.key, min_first);
    assign pick_any   = right_wins || left_ok;
    assign pick_ent   = right_wins ? rd_b_reg : rd_a_reg;
    assign pick_pos   = right_wins ? right_pos : left_pos;

    always_comb begin
        stat.req_type = req_reg.req_type;
        stat.full     = count_reg == POS_W'(CAPACITY);
        stat.empty    = count_reg == '0;
        stat.bad_pos  = (req_reg.position == '0) || (req_reg.position > count_reg);
        stat.pos_last = req_reg.position == count_reg;
        stat.up_go    = (pos_reg > POS_W'(1)) && beats(cur_reg.key, rd_a_reg.key, min_first);
        stat.dn_go    = pick_any && beats(pick_ent.key, cur_reg.key, min_first);
    end

    always_comb begin
        rd_en    = 1'b0;
        rd_a_idx = '0;
        rd_b_idx = '0;
        wr_en    = 1'b0;
        wr_idx   = '0;
        wr_data  = cur_reg;
        sw_en    = 1'b0;
        sw_hdl   = cur_reg.handle;
        sw_pos   = pos_reg;
        case (cmd.op)
            OP_INS_WR: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx(cnt_inc);
                wr_data = '{key: req_reg.key, handle: req_reg.handle};
                sw_en   = 1'b1;
                sw_hdl  = req_reg.handle;
                sw_pos  = cnt_inc[POS_W-1:0];
            end
            OP_RD_PARENT: begin
                rd_en    = 1'b1;
                rd_a_idx = pos_to_idx(parent_pos);
            end
            OP_UP_W1: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx({1'b0, pos_reg});
                wr_data = rd_a_reg;
                sw_en   = 1'b1;
                sw_hdl  = rd_a_reg.handle;
                sw_pos  = pos_reg;
            end
            OP_UP_W2: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx(parent_pos);
                wr_data = cur_reg;
                sw_en   = 1'b1;
                sw_hdl  = cur_reg.handle;
                sw_pos  = parent_pos[POS_W-1:0];
            end
            OP_RD_ROOT: begin
                rd_en    = 1'b1;
                rd_a_idx = '0;
                rd_b_idx = pos_to_idx(count_ext);
            end
            OP_DQ_W: begin
                wr_en   = 1'b1;
                wr_idx  = '0;
                wr_data = rd_b_reg;
                sw_en   = 1'b1;
                sw_hdl  = rd_b_reg.handle;
                sw_pos  = POS_W'(1);
            end
            OP_RD_REM: begin
                rd_en    = 1'b1;
                rd_a_idx = pos_to_idx({1'b0, req_reg.position});
                rd_b_idx = pos_to_idx(count_ext);
            end
            OP_RM_W1: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx({1'b0, req_reg.position});
                wr_data = rd_b_reg;
                sw_en   = 1'b1;
                sw_hdl  = rd_b_reg.handle;
                sw_pos  = req_reg.position;
            end
            OP_RM_W2: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx(count_ext);
                wr_data = rd_a_reg;
                sw_en   = 1'b1;
                sw_hdl  = rd_a_reg.handle;
                sw_pos  = count_reg;
            end
            OP_RD_KIDS: begin
                rd_en    = 1'b1;
                rd_a_idx = pos_to_idx(left_pos);
                rd_b_idx = pos_to_idx(right_pos);
            end
            OP_DN_W1: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx(pick_pos);
                wr_data = cur_reg;
                sw_en   = 1'b1;
                sw_hdl  = cur_reg.handle;
                sw_pos  = pick_pos[POS_W-1:0];
            end
            OP_DN_W2: begin
                wr_en   = 1'b1;
                wr_idx  = pos_to_idx({1'b0, pos_reg});
                wr_data = child_reg;
                sw_en   = 1'b1;
                sw_hdl  = child_reg.handle;
                sw_pos  = pos_reg;
            end
            default: begin
            end
        endcase
    end

    // heap memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= heap_mem[rd_a_idx];
            rd_b_reg <= heap_mem[rd_b_idx];
        end
    end

    // handle to position memory
    always_ff @(posedge aclk) begin
        if (sw_en) begin
            slot_mem[sw_hdl] <= sw_pos;
        end
        if (cmd.op == OP_RD_SLOT) begin
            slot_rd_reg <= slot_mem[req_reg.handle];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case (cmd.op)
                OP_INS_WR:                   count_reg <= cnt_inc[POS_W-1:0];
                OP_DQ_W, OP_RM_W2, OP_RM_LAST: count_reg <= count_reg - 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                req_reg    <= s_data;
                status_reg <= ST_OK;
                okey_reg   <= '0;
                ohdl_reg   <= '0;
                opos_reg   <= '0;
            end
            OP_FLAG: status_reg <= cmd.flag;
            OP_INS_WR: begin
                cur_reg <= '{key: req_reg.key, handle: req_reg.handle};
                pos_reg <= cnt_inc[POS_W-1:0];
            end
            OP_UP_W2: pos_reg <= parent_pos[POS_W-1:0];
            OP_DQ_W: begin
                okey_reg <= rd_a_reg.key;
                ohdl_reg <= rd_a_reg.handle;
                cur_reg  <= rd_b_reg;
                pos_reg  <= POS_W'(1);
            end
            OP_PEEK: begin
                okey_reg <= rd_a_reg.key;
                ohdl_reg <= rd_a_reg.handle;
            end
            OP_RM_W2: begin
                cur_reg <= rd_b_reg;
                pos_reg <= req_reg.position;
            end
            OP_DN_W1: begin
                pick_reg  <= pick_pos[POS_W-1:0];
                child_reg <= pick_ent;
            end
            OP_DN_W2: pos_reg <= pick_reg;
            OP_LOC_OUT: opos_reg <= slot_rd_reg;
            default: begin
            end
        endcase
    end

    always_comb begin
        rsp.status       = status_reg;
        rsp.out_key      = okey_reg;
        rsp.out_handle   = ohdl_reg;
        rsp.out_position = opos_reg;
        rsp.entry_count  = count_reg;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= POS_W'(CAPACITY))
        else $error("entry count above capacity");
    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_INS_WR |-> count_reg < POS_W'(CAPACITY))
        else $error("insert issued on a full heap");
    a_down_moves_deeper: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_DN_W1 |-> pick_pos > {1'b0, pos_reg} && pick_pos <= count_ext)
        else $error("sift-down pick outside heap");
`endif

endmodule

// ===== hdl/hpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpq_ctrl
// Request sequencer: decodes an item and steps the sift loops.
// ----------------------------------------------------------------------------
module hpq_ctrl import hpq_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  hpq_stat_t stat,
    output hpq_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_DECODE = 14'b00000000000010,
        S_UP_RD  = 14'b00000000000100,
        S_UP_CMP = 14'b00000000001000,
        S_UP_W2  = 14'b00000000010000,
        S_DQ_W   = 14'b00000000100000,
        S_PEEK   = 14'b00000001000000,
        S_RM_W1  = 14'b00000010000000,
        S_RM_W2  = 14'b00000100000000,
        S_DN_RD  = 14'b00001000000000,
        S_DN_CMP = 14'b00010000000000,
        S_DN_W2  = 14'b00100000000000,
        S_LOC    = 14'b01000000000000,
        S_RESP   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   down_after_reg, down_after_next;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_RESP;

    always_comb begin
        state_next      = state_reg;
        down_after_next = down_after_reg;
        cmd.op          = OP_NONE;
        cmd.flag        = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_RESP;
                unique case (stat.req_type)
                    REQ_INSERT: begin
                        if (stat.full) begin
                            cmd.op   = OP_FLAG;
                            cmd.flag = ST_FULL;
                        end else begin
                            cmd.op          = OP_INS_WR;
                            down_after_next = 1'b0;
                            state_next      = S_UP_RD;
                        end
                    end
                    REQ_DEQUEUE, REQ_PEEK: begin
                        if (stat.empty) begin
                            cmd.op   = OP_FLAG;
                            cmd.flag = ST_EMPTY;
                        end else begin
                            cmd.op     = OP_RD_ROOT;
                            state_next = (stat.req_type == REQ_DEQUEUE) ? S_DQ_W : S_PEEK;
                        end
                    end
                    REQ_REMOVE: begin
                        if (stat.bad_pos) begin
                            cmd.op   = OP_FLAG;
                            cmd.flag = ST_BAD_POS;
                        end else if (stat.pos_last) begin
                            cmd.op = OP_RM_LAST;
                        end else begin
                            cmd.op     = OP_RD_REM;
                            state_next = S_RM_W1;
                        end
                    end
                    REQ_LOCATE: begin
                        cmd.op     = OP_RD_SLOT;
                        state_next = S_LOC;
                    end
                    default: begin
                    end
                endcase
            end
            S_UP_RD: begin
                cmd.op     = OP_RD_PARENT;
                state_next = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (stat.up_go) begin
                    cmd.op     = OP_UP_W1;
                    state_next = S_UP_W2;
                end else begin
                    state_next = down_after_reg ? S_DN_RD : S_RESP;
                end
            end
            S_UP_W2: begin
                cmd.op          = OP_UP_W2;
                down_after_next = 1'b0;
                state_next      = S_UP_RD;
            end
            S_DQ_W: begin
                cmd.op     = OP_DQ_W;
                state_next = S_DN_RD;
            end
            S_PEEK: begin
                cmd.op     = OP_PEEK;
                state_next = S_RESP;
            end
            S_RM_W1: begin
                cmd.op     = OP_RM_W1;
                state_next = S_RM_W2;
            end
            S_RM_W2: begin
                cmd.op          = OP_RM_W2;
                down_after_next = 1'b1;
                state_next      = S_UP_RD;
            end
            S_DN_RD: begin
                cmd.op     = OP_RD_KIDS;
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (stat.dn_go) begin
                    cmd.op     = OP_DN_W1;
                    state_next = S_DN_W2;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_DN_W2: begin
                cmd.op     = OP_DN_W2;
                state_next = S_DN_RD;
            end
            S_LOC: begin
                cmd.op     = OP_LOC_OUT;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            down_after_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            down_after_reg <= down_after_next;
        end
    end

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result is pending");
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DECODE)
        else $error("accepted item not decoded");
    a_up_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_UP_CMP |-> $past(state_reg) == S_UP_RD)
        else $error("parent compare without read");
`endif

endmodule

// ===== hdl/binary_heap_priority_queue.sv =====
// Sift loops: each sift level is a registered heap read, a compare and a two-step swap write;
//   a sift moves at most 6 levels for 64 entries.
// Throughput: one item at a time; the next item is taken once the result has been taken.
// Reset: aresetn synchronous, active low; empties the heap and sets min_first to 0.
//   Heap and handle memories are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap of (key, handle) entries with insert, dequeue, peek, remove
// and handle locate, plus an APB register for max/min ordering.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue import hpq_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  hpq_req_t           s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output hpq_rsp_t           m_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic      min_first_reg;
    hpq_cmd_t  cmd;
    hpq_stat_t stat;

    // single register: bit 0 selects min-first ordering
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_FIRST) ? {31'b0, min_first_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_first_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_FIRST) begin
            min_first_reg <= pwdata[0];
        end
    end

    // sequencer: one state per memory access or write step
    hpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memories, working entry, result registers (held while m_valid)
    hpq_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .min_first (min_first_reg),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (m_data)
    );

endmodule

// ===== sim/binary_heap_priority_queue_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_test
// Self-checking bench for the heap priority queue. A directed table covers
// the empty and bad-position flags, extreme keys and handles, and unused
// request codes. A fill to capacity shows the full flag. Random traffic then
// runs in max and min ordering under varied handshake idling. Every result
// item is compared field by field with its directed row or with a heap mirror.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_test;
    import hpq_pkg::*;

    localparam time         HALF_PERIOD = 6ns;
    localparam logic [2:0]  REQ_UNUSED  = REQ_LOCATE + 3'd1;  // first unused code

    // one row of the directed table; typed expectation when known_rsp is set
    typedef struct {
        hpq_req_t req;
        bit       known_rsp;
        hpq_rsp_t rsp;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    hpq_req_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    hpq_rsp_t           m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // heap mirror, positions 1..CAPACITY
    logic [KEY_W-1:0]    mir_key [1:CAPACITY];
    logic [HANDLE_W-1:0] mir_hdl [1:CAPACITY];
    logic [POS_W-1:0]    mir_slot [NUM_HANDLES];
    bit                  hdl_seen [NUM_HANDLES];
    int                  mir_count = 0;
    logic                mir_min_first = 1'b0;

    hpq_rsp_t pending_rsp[$];
    int       snd_idle = 0;       // percent of cycles the sender idles
    int       rcv_idle = 0;       // percent of cycles the receiver idles
    int       hold_off = 0;       // long receiver stall, in cycles
    int       n_fail = 0;
    int       n_items = 0;
    int       n_rsp = 0;
    int       n_full = 0;
    int       n_empty = 0;
    int       n_bad = 0;

    always #HALF_PERIOD aclk = ~aclk;

    binary_heap_priority_queue uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ---------------------------------------------------------------- mirror
    function automatic bit outranks(int a, int b);
        return mir_min_first ? (mir_key[a] < mir_key[b]) : (mir_key[a] > mir_key[b]);
    endfunction

    // swap two slots and note where both handles now live
    function automatic void swap_slots(int a, int b);
        logic [KEY_W-1:0]    k;
        logic [HANDLE_W-1:0] h;
        k = mir_key[a];
        h = mir_hdl[a];
        mir_key[a] = mir_key[b];
        mir_hdl[a] = mir_hdl[b];
        mir_key[b] = k;
        mir_hdl[b] = h;
        mir_slot[mir_hdl[a]] = POS_W'(a);
        mir_slot[mir_hdl[b]] = POS_W'(b);
    endfunction

    function automatic void bubble_up(int p);
        while (p > 1 && outranks(p, p / 2)) begin
            swap_slots(p, p / 2);
            p = p / 2;
        end
    endfunction

    // ties go to the left child; a move needs strictly higher priority
    function automatic void bubble_down(int p);
        int l;
        int pick;
        forever begin
            l = 2 * p;
            pick = p;
            if (l + 1 <= mir_count && outranks(l + 1, l))
                pick = l + 1;
            else if (l <= mir_count)
                pick = l;
            if (pick == p || !outranks(pick, p))
                return;
            swap_slots(pick, p);
            p = pick;
        end
    endfunction

    // applies one request to the mirror and returns the result it gives
    function automatic hpq_rsp_t heap_response(hpq_req_t r);
        hpq_rsp_t o;
        int       p;
        o = '0;
        o.status = ST_OK;
        p = r.position;
        case (r.req_type)
            REQ_INSERT: begin
                if (mir_count >= CAPACITY) begin
                    o.status = ST_FULL;
                end else begin
                    mir_count++;
                    mir_key[mir_count] = r.key;
                    mir_hdl[mir_count] = r.handle;
                    mir_slot[r.handle] = POS_W'(mir_count);
                    hdl_seen[r.handle] = 1'b1;
                    bubble_up(mir_count);
                end
            end
            REQ_DEQUEUE, REQ_PEEK: begin
                if (mir_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.out_key = mir_key[1];
                    o.out_handle = mir_hdl[1];
                    if (r.req_type == REQ_DEQUEUE) begin
                        mir_key[1] = mir_key[mir_count];
                        mir_hdl[1] = mir_hdl[mir_count];
                        mir_slot[mir_hdl[1]] = POS_W'(1);
                        mir_count--;
                        bubble_down(1);
                    end
                end
            end
            REQ_REMOVE: begin
                if (p == 0 || p > mir_count) begin
                    o.status = ST_BAD_POS;
                end else if (p == mir_count) begin
                    mir_count--;
                end else begin
                    swap_slots(p, mir_count);
                    mir_count--;
                    if (p > 1 && outranks(p, p / 2))
                        bubble_up(p);
                    else
                        bubble_down(p);
                end
            end
            REQ_LOCATE: o.out_position = mir_slot[r.handle];
            default: ;
        endcase
        o.entry_count = POS_W'(mir_count);
        return o;
    endfunction

    // ---------------------------------------------------------------- sender
    // valid stays high from one item to the next unless the sender idles; only one assignment per edge
    task automatic send_req(hpq_req_t r, bit known_rsp = 1'b0, hpq_rsp_t rsp = '0);
        hpq_rsp_t p;
        @(negedge aclk);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            s_data <= hpq_req_t'(48'({$urandom, $urandom}));   // noise while idle
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        do @(posedge aclk); while (!s_ready);
        p = heap_response(r);
        pending_rsp.push_back(known_rsp ? rsp : p);
        n_items++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // let all results drain, plus the block's worst latency
    task automatic drain();
        stop_sending();
        while (pending_rsp.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_min_first(logic v);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_MIN_FIRST;
        pwdata <= {31'($urandom), v};   // upper bits are don't-care
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mir_min_first = v;
    endtask

    function automatic hpq_req_t mk_req(logic [2:0] t, logic [KEY_W-1:0] k,
                                        logic [HANDLE_W-1:0] h, logic [POS_W-1:0] p);
        hpq_req_t r;
        r.req_type = t;
        r.key = k;
        r.handle = h;
        r.position = p;
        return r;
    endfunction

    function automatic hpq_rsp_t mk_rsp(status_t s, logic [KEY_W-1:0] k,
                                        logic [HANDLE_W-1:0] h, logic [POS_W-1:0] p,
                                        logic [POS_W-1:0] c);
        hpq_rsp_t o;
        o.status = s;
        o.out_key = k;
        o.out_handle = h;
        o.out_position = p;
        o.entry_count = c;
        return o;
    endfunction

    // random item: mostly inserts and dequeues, keys often bunched for ties
    function automatic hpq_req_t rand_req();
        int       pick;
        int       h;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: k = $urandom_range(7);
            1: k = $urandom_range(1) ? '1 : '0;
            default: k = $urandom;
        endcase
        h = $urandom_range(NUM_HANDLES - 1);
        if (pick < 40)
            return mk_req(REQ_INSERT, k, HANDLE_W'(h), POS_W'($urandom));
        if (pick < 60)
            return mk_req(REQ_DEQUEUE, k, HANDLE_W'(h), POS_W'($urandom));
        if (pick < 68)
            return mk_req(REQ_PEEK, k, HANDLE_W'(h), POS_W'($urandom));
        if (pick < 88)
            return mk_req(REQ_REMOVE, k, HANDLE_W'(h),
                          POS_W'($urandom_range(9) == 0 ? CAPACITY
                                                        : $urandom_range(mir_count + 2)));
        if (pick < 97) begin
            // only locate handles that have been stored at some point
            while (!hdl_seen[h])
                h = $urandom_range(NUM_HANDLES - 1);
            if (mir_count == 0 && !hdl_seen[h])
                return mk_req(REQ_PEEK, k, HANDLE_W'(h), '0);
            return mk_req(REQ_LOCATE, k, HANDLE_W'(h), POS_W'($urandom));
        end
        return mk_req(3'(REQ_UNUSED + $urandom_range(2)), k, HANDLE_W'(h), POS_W'($urandom));
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_req(rand_req());
    endtask

    // ---------------------------------------------------------------- receiver
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        hpq_rsp_t e;
        if (aresetn && m_valid && m_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
                $display("%t: result with nothing expected: %p", $realtime, m_data);
                n_fail++;
            end else begin
                e = pending_rsp.pop_front();
                case (e.status)
                    ST_FULL:    n_full++;
                    ST_EMPTY:   n_empty++;
                    ST_BAD_POS: n_bad++;
                    default: ;
                endcase
                if (m_data.status !== e.status) begin
                    $display("%t: status exp %s got %0d", $realtime, e.status.name(),
                             m_data.status);
                    n_fail++;
                end
                if (m_data.out_key !== e.out_key) begin
                    $display("%t: out_key exp %h got %h", $realtime, e.out_key,
                             m_data.out_key);
                    n_fail++;
                end
                if (m_data.out_handle !== e.out_handle) begin
                    $display("%t: out_handle exp %0d got %0d", $realtime, e.out_handle,
                             m_data.out_handle);
                    n_fail++;
                end
                if (m_data.out_position !== e.out_position) begin
                    $display("%t: out_position exp %0d got %0d", $realtime,
                             e.out_position, m_data.out_position);
                    n_fail++;
                end
                if (m_data.entry_count !== e.entry_count) begin
                    $display("%t: entry_count exp %0d got %0d", $realtime,
                             e.entry_count, m_data.entry_count);
                    n_fail++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #25ms;
        $display("timeout with %0d results outstanding", pending_rsp.size());
        $display("binary_heap_priority_queue: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- main
    initial begin
        dir_row_t dir_tbl[$];
        foreach (hdl_seen[i]) hdl_seen[i] = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, max ordering after reset
        dir_tbl = '{
            '{mk_req(REQ_DEQUEUE, '0, '0, '0), 1, mk_rsp(ST_EMPTY, '0, '0, '0, '0)},
            '{mk_req(REQ_PEEK, '1, '1, '1), 1, mk_rsp(ST_EMPTY, '0, '0, '0, '0)},
            '{mk_req(REQ_REMOVE, '0, '0, '0), 1, mk_rsp(ST_BAD_POS, '0, '0, '0, '0)},
            '{mk_req(REQ_INSERT, '1, '1, '0), 1, mk_rsp(ST_OK, '0, '0, '0, 7'd1)},
            '{mk_req(REQ_INSERT, '0, '0, '1), 1, mk_rsp(ST_OK, '0, '0, '0, 7'd2)},
            '{mk_req(REQ_PEEK, '0, '0, '0), 1, mk_rsp(ST_OK, '1, '1, '0, 7'd2)},
            '{mk_req(REQ_LOCATE, '0, '1, '0), 1, mk_rsp(ST_OK, '0, '0, 7'd1, 7'd2)},
            '{mk_req(REQ_LOCATE, '0, '0, '0), 1, mk_rsp(ST_OK, '0, '0, 7'd2, 7'd2)},
            '{mk_req(REQ_REMOVE, '0, '0, 7'd3), 1, mk_rsp(ST_BAD_POS, '0, '0, '0, 7'd2)},
            '{mk_req(REQ_REMOVE, '0, '0, 7'd64), 1, mk_rsp(ST_BAD_POS, '0, '0, '0, 7'd2)},
            '{mk_req(REQ_UNUSED, '1, '1, '1), 1, mk_rsp(ST_OK, '0, '0, '0, 7'd2)},
            '{mk_req(REQ_UNUSED + 3'd2, '1, '1, '1), 1, mk_rsp(ST_OK, '0, '0, '0, 7'd2)},
            '{mk_req(REQ_REMOVE, '0, '0, 7'd2), 1, mk_rsp(ST_OK, '0, '0, '0, 7'd1)},
            '{mk_req(REQ_DEQUEUE, '0, '0, '0), 1, mk_rsp(ST_OK, '1, '1, '0, 7'd0)},
            // dequeued handle keeps position one
            '{mk_req(REQ_LOCATE, '0, '1, '0), 1, mk_rsp(ST_OK, '0, '0, 7'd1, 7'd0)},
            // ties: equal keys, then removal from the middle
            '{mk_req(REQ_INSERT, 32'd5, 6'd10, '0), 0, '0},
            '{mk_req(REQ_INSERT, 32'd5, 6'd11, '0), 0, '0},
            '{mk_req(REQ_INSERT, 32'd5, 6'd12, '0), 0, '0},
            '{mk_req(REQ_INSERT, 32'd9, 6'd13, '0), 0, '0},
            '{mk_req(REQ_INSERT, 32'd1, 6'd10, '0), 0, '0},
            '{mk_req(REQ_REMOVE, '0, '0, 7'd2), 0, '0},
            '{mk_req(REQ_LOCATE, '0, 6'd10, '0), 0, '0},
            '{mk_req(REQ_DEQUEUE, '0, '0, '0), 0, '0},
            '{mk_req(REQ_REMOVE, '0, '0, 7'd1), 0, '0}
        };
        foreach (dir_tbl[i])
            send_req(dir_tbl[i].req, dir_tbl[i].known_rsp, dir_tbl[i].rsp);

        // random, max ordering, sender idles lightly, receiver heavily
        snd_idle = 15;
        rcv_idle = 46;
        random_phase(240);
        drain();

        // min ordering, idling the other way round
        write_min_first(1'b1);
        snd_idle = 46;
        rcv_idle = 15;
        random_phase(240);
        drain();

        // back-pressure: receiver stalls long while inserts keep coming,
        // then the heap is topped up to capacity and overflowed
        write_min_first(1'b0);
        snd_idle = 0;
        rcv_idle = 0;
        hold_off = 300;
        while (mir_count < CAPACITY)
            send_req(mk_req(REQ_INSERT, $urandom, HANDLE_W'($urandom), '0));
        send_req(mk_req(REQ_INSERT, '1, '1, '0));
        send_req(mk_req(REQ_REMOVE, '0, '0, 7'd64));
        drain();

        write_min_first(1'b1);
        random_phase(220);
        drain();

        $display("%0d items sent, %0d results checked: %0d full, %0d empty, %0d bad position",
                 n_items, n_rsp, n_full, n_empty, n_bad);
        $display("both orderings, long receiver stall and a heap filled past capacity");
        if (n_fail == 0 && pending_rsp.size() == 0) begin
            $display("binary_heap_priority_queue: match");
        end else begin
            $display("binary_heap_priority_queue: mismatch");
        end
        $finish;
    end

endmodule

// ===== binary_heap_priority_queue.f =====
hdl/hpq_pkg.sv
hdl/hpq_datapath.sv
hdl/hpq_ctrl.sv
hdl/binary_heap_priority_queue.sv
sim/binary_heap_priority_queue_test.sv
